/* design/assert_macros.svh */
// Assertion macros shared by the presence idle sleep controller RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define PSC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define PSC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/psc_pkg.sv */
// Package of the presence idle sleep controller: widths, codes, reset values
// and the configuration struct. No dependencies.
`default_nettype none

package psc_pkg;

  localparam int unsigned TimeW    = 32;
  localparam int unsigned ModeW    = 2;
  localparam int unsigned StatusW  = 4;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned WinW     = 16;

  localparam logic [WinW-1:0] PresenceWindowRst = WinW'(500);
  localparam logic [WinW-1:0] SleepTimeoutRst   = WinW'(7000);
  localparam logic [WinW-1:0] WakeGraceRst      = WinW'(1500);

  typedef enum logic [ModeW-1:0] {
    MODE_FACE    = 2'd0,
    MODE_POLL    = 2'd1,
    MODE_RESTART = 2'd2
  } mode_e;

  typedef enum logic [StatusW-1:0] {
    ST_FACE_NOTED   = 4'd0,
    ST_FACE_IGNORED = 4'd1,
    ST_DISABLED     = 4'd2,
    ST_BUSY         = 4'd3,
    ST_OVERRIDE     = 4'd4,
    ST_GRACE        = 4'd5,
    ST_PRESENT      = 4'd6,
    ST_COUNTING     = 4'd7,
    ST_SLEPT        = 4'd8,
    ST_ASLEEP       = 4'd9,
    ST_WOKEN        = 4'd10,
    ST_RESTARTED    = 4'd11
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_COUNTER_ENABLE = 3'd0,
    CFG_SLEEP_OVERRIDE = 3'd1,
    CFG_PRESENCE_WIN   = 3'd2,
    CFG_SLEEP_TIMEOUT  = 3'd3,
    CFG_WAKE_GRACE     = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic            counter_enable;
    logic            sleep_override;
    logic [WinW-1:0] presence_window_ms;
    logic [WinW-1:0] sleep_timeout_ms;
    logic [WinW-1:0] wake_guard_ms;
  } cfg_t;

endpackage

`default_nettype wire

/* design/psc_in_if.sv */
// Input event channel of the presence idle sleep controller.
// Depends on psc_pkg for field widths.
`default_nettype none

interface psc_in_if;
  logic                       valid;
  logic                       ready;
  logic [psc_pkg::ModeW-1:0]  mode;
  logic [psc_pkg::TimeW-1:0]  now_ms;
  logic                       face_seen;
  logic                       pipeline_busy;
  logic                       touch_valid;
  logic                       touch_pressed;

  modport source (
    output valid, mode, now_ms, face_seen, pipeline_busy, touch_valid, touch_pressed,
    input  ready
  );
  modport sink (
    input  valid, mode, now_ms, face_seen, pipeline_busy, touch_valid, touch_pressed,
    output ready
  );
endinterface

`default_nettype wire

/* design/psc_out_if.sv */
// Result channel of the presence idle sleep controller.
// Depends on psc_pkg for field widths.
`default_nettype none

interface psc_out_if;
  logic                         valid;
  logic                         ready;
  logic                         asleep;
  logic [psc_pkg::StatusW-1:0]  status;

  modport source (output valid, asleep, status, input ready);
  modport sink   (input valid, asleep, status, output ready);
endinterface

`default_nettype wire

/* design/psc_cfg_regs.sv */
// Configuration register file of the presence idle sleep controller.
// Depends on psc_pkg.
`default_nettype none

module psc_cfg_regs (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [psc_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire logic [psc_pkg::CfgDataW-1:0]   cfg_wdata_i,
  output psc_pkg::cfg_t                       cfg_o
);

  psc_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.counter_enable     <= 1'b0;
      cfg_q.sleep_override     <= 1'b0;
      cfg_q.presence_window_ms <= psc_pkg::PresenceWindowRst;
      cfg_q.sleep_timeout_ms   <= psc_pkg::SleepTimeoutRst;
      cfg_q.wake_guard_ms      <= psc_pkg::WakeGraceRst;
    end else if (cfg_we_i) begin
      unique case (psc_pkg::cfg_idx_e'(cfg_idx_i))
        psc_pkg::CFG_COUNTER_ENABLE: cfg_q.counter_enable <= cfg_wdata_i[0];
        psc_pkg::CFG_SLEEP_OVERRIDE: cfg_q.sleep_override <= cfg_wdata_i[0];
        psc_pkg::CFG_PRESENCE_WIN: begin
          cfg_q.presence_window_ms <= cfg_wdata_i[psc_pkg::WinW-1:0];
        end
        psc_pkg::CFG_SLEEP_TIMEOUT: begin
          cfg_q.sleep_timeout_ms <= cfg_wdata_i[psc_pkg::WinW-1:0];
        end
        psc_pkg::CFG_WAKE_GRACE: begin
          cfg_q.wake_guard_ms <= cfg_wdata_i[psc_pkg::WinW-1:0];
        end
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

/* design/psc_engine.sv */
// Event engine: input register, decision logic with the sleep state, and
// the result register. Depends on psc_pkg, psc_in_if, psc_out_if and the macros.
`default_nettype none
`include "assert_macros.svh"

module psc_engine (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  psc_pkg::cfg_t  cfg_i,
  psc_in_if.sink         in_ch,
  psc_out_if.source      out_ch
);

  logic                            in_v_q;
  logic [psc_pkg::ModeW-1:0]       mode_q;
  logic [psc_pkg::TimeW-1:0]       now_q;
  logic                            face_q;
  logic                            busy_q;
  logic                            tvalid_q;
  logic                            tpress_q;

  logic                            sleep_q, sleep_d;
  logic                            prev_touch_q, prev_touch_d;
  logic [psc_pkg::TimeW-1:0]       last_face_q, last_face_d;
  logic [psc_pkg::TimeW-1:0]       wake_q, wake_d;

  logic                            out_v_q;
  logic                            out_asleep_q;
  psc_pkg::status_e                out_status_q;

  psc_pkg::status_e                st_d;
  logic                            adv;
  logic                            rise;
  logic [psc_pkg::TimeW-1:0]       since_wake;
  logic [psc_pkg::TimeW-1:0]       face_age;
  logic [psc_pkg::TimeW-1:0]       grace_w;
  logic [psc_pkg::TimeW-1:0]       window_w;
  logic [psc_pkg::TimeW-1:0]       timeout_w;

  assign adv         = in_v_q && (!out_v_q || out_ch.ready);
  assign in_ch.ready = !in_v_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (in_ch.ready) begin
      in_v_q <= in_ch.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ch.valid && in_ch.ready) begin
      mode_q   <= in_ch.mode;
      now_q    <= in_ch.now_ms;
      face_q   <= in_ch.face_seen;
      busy_q   <= in_ch.pipeline_busy;
      tvalid_q <= in_ch.touch_valid;
      tpress_q <= in_ch.touch_pressed;
    end
  end

  assign since_wake = now_q - wake_q;
  assign face_age   = now_q - last_face_q;
  assign grace_w    = psc_pkg::TimeW'(cfg_i.wake_guard_ms);
  assign window_w   = psc_pkg::TimeW'(cfg_i.presence_window_ms);
  assign timeout_w  = psc_pkg::TimeW'(cfg_i.sleep_timeout_ms);
  assign rise       = tpress_q && !prev_touch_q;

  always_comb begin
    sleep_d      = sleep_q;
    prev_touch_d = prev_touch_q;
    last_face_d  = last_face_q;
    wake_d       = wake_q;
    st_d         = psc_pkg::ST_FACE_IGNORED;
    unique case (psc_pkg::mode_e'(mode_q))
      psc_pkg::MODE_FACE: begin
        if (cfg_i.counter_enable && face_q) begin
          last_face_d = now_q;
          st_d        = psc_pkg::ST_FACE_NOTED;
        end
      end
      psc_pkg::MODE_POLL: begin
        priority if (!cfg_i.counter_enable) begin
          st_d = psc_pkg::ST_DISABLED;
        end else if (busy_q) begin
          st_d = psc_pkg::ST_BUSY;
        end else if (cfg_i.sleep_override) begin
          st_d = psc_pkg::ST_OVERRIDE;
        end else if (!sleep_q && (since_wake < grace_w)) begin
          prev_touch_d = 1'b0;
          st_d         = psc_pkg::ST_GRACE;
        end else if (!sleep_q && (face_age < window_w)) begin
          st_d = psc_pkg::ST_PRESENT;
        end else if (!sleep_q && (face_age > timeout_w)) begin
          sleep_d      = 1'b1;
          prev_touch_d = 1'b0;
          st_d         = psc_pkg::ST_SLEPT;
        end else if (!sleep_q) begin
          st_d = psc_pkg::ST_COUNTING;
        end else if (tvalid_q && rise) begin
          prev_touch_d = tpress_q;
          sleep_d      = 1'b0;
          last_face_d  = now_q;
          wake_d       = now_q;
          st_d         = psc_pkg::ST_WOKEN;
        end else if (tvalid_q) begin
          prev_touch_d = tpress_q;
          st_d         = psc_pkg::ST_ASLEEP;
        end else begin
          st_d = psc_pkg::ST_ASLEEP;
        end
      end
      psc_pkg::MODE_RESTART: begin
        last_face_d = now_q;
        st_d        = psc_pkg::ST_RESTARTED;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sleep_q      <= 1'b0;
      prev_touch_q <= 1'b0;
      last_face_q  <= '0;
      wake_q       <= '0;
    end else if (adv) begin
      sleep_q      <= sleep_d;
      prev_touch_q <= prev_touch_d;
      last_face_q  <= last_face_d;
      wake_q       <= wake_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv) begin
      out_v_q <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_asleep_q <= sleep_d;
      out_status_q <= st_d;
    end
  end

  assign out_ch.valid  = out_v_q;
  assign out_ch.asleep = out_asleep_q;
  assign out_ch.status = out_status_q;

  `PSC_ASSERT(a_slept_sets_flag, clk_i, rst_ni, (adv && st_d == psc_pkg::ST_SLEPT) |=> sleep_q, "sleep entry did not set the flag")
  `PSC_ASSERT(a_woken_aligns_times, clk_i, rst_ni, (adv && st_d == psc_pkg::ST_WOKEN) |=> (!sleep_q && wake_q == last_face_q), "wake did not align stored times")
  `PSC_ASSERT(a_state_holds_idle, clk_i, rst_ni, !adv |=> ($stable(sleep_q) && $stable(last_face_q)), "state changed without a transaction")
  `PSC_ASSERT(a_result_matches_flag, clk_i, rst_ni, adv |=> (out_asleep_q == sleep_q && out_v_q), "result does not match the sleep flag")

endmodule

`default_nettype wire

/* design/presence_idle_sleep_controller_unit.sv */
// Presence idle sleep controller: one event in, one result out per transaction.
// The input register takes the event; the result register then holds the result.
// Throughput: one per cycle, set by single-pass decision logic, unless out_ch stalls.
// Reset: asynchronous, active low; clears the sleep state, both stored times,
// the touch level and the channel valids, and loads the register defaults.
// Depends on psc_pkg, psc_in_if, psc_out_if, psc_cfg_regs and psc_engine.
`default_nettype none

module presence_idle_sleep_controller_unit (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [psc_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire logic [psc_pkg::CfgDataW-1:0]   cfg_wdata_i,
  psc_in_if.sink                              in_ch,
  psc_out_if.source                           out_ch
);

  psc_pkg::cfg_t cfg;

  psc_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  psc_engine u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule

`default_nettype wire

/* test/tb.sv */
// Self-checking testbench for presence_idle_sleep_controller_unit: random and directed
// events go in, each result is compared with an in-bench prediction of the sleep logic.
// Depends on psc_pkg, psc_in_if, psc_out_if and the controller RTL.
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [psc_pkg::ModeW-1:0]   ModeUnused  = 2'd3;
  localparam logic [psc_pkg::CfgIdxW-1:0] CfgIdxSpare = 3'd5;
  localparam logic [psc_pkg::CfgIdxW-1:0] CfgIdxTop   = 3'd7;
  localparam int unsigned                 PhaseCount  = 8;
  localparam int unsigned                 PhaseEvents = 180;
  localparam int unsigned                 HoldCycles  = 400;
  localparam int unsigned                 IdleLimit   = 3000;
  localparam int unsigned                 MaxReports  = 10;

  typedef struct packed {
    logic [psc_pkg::ModeW-1:0] mode;
    logic [psc_pkg::TimeW-1:0] now_ms;
    logic                      face_seen;
    logic                      pipeline_busy;
    logic                      touch_valid;
    logic                      touch_pressed;
  } sensor_event_t;

  typedef struct packed {
    logic             asleep;
    psc_pkg::status_e status;
  } sleep_result_t;

  typedef enum int unsigned {StallNone, StallHalf, StallLight, StallHeavy} stall_style_e;

  logic                         clk;
  logic                         rst_ni;
  logic                         cfg_we;
  logic [psc_pkg::CfgIdxW-1:0]  cfg_idx;
  logic [psc_pkg::CfgDataW-1:0] cfg_wdata;

  psc_in_if  in_ch();
  psc_out_if out_ch();

  presence_idle_sleep_controller_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  psc_pkg::cfg_t             cfg_model = '{1'b0, 1'b0, psc_pkg::PresenceWindowRst,
                                           psc_pkg::SleepTimeoutRst, psc_pkg::WakeGraceRst};
  logic                      asleep_q = 1'b0;
  logic [psc_pkg::TimeW-1:0] last_face_at = '0;
  logic [psc_pkg::TimeW-1:0] wake_at = '0;
  logic                      touch_prev = 1'b0;

  sensor_event_t pending_events[$];
  sleep_result_t awaited_results[$];
  sensor_event_t next_event;
  sleep_result_t seen_result;

  logic                      in_fire = 1'b0;
  int unsigned               burst_left = 0;
  int unsigned               gap_left = 0;
  int unsigned               hold_left = 0;
  int unsigned               hold_requests = 0;
  int unsigned               holds_served = 0;
  int unsigned               run_left = 0;
  stall_style_e              stall_style = StallNone;
  int unsigned               idle_cycles = 0;
  int unsigned               mismatch_count = 0;
  logic [psc_pkg::TimeW-1:0] clock_ms = '0;
  logic                      touch_level = 1'b0;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  function automatic sleep_result_t advance_sleep_model(sensor_event_t ev);
    logic [psc_pkg::TimeW-1:0] since_wake;
    logic [psc_pkg::TimeW-1:0] face_age;
    sleep_result_t             res;
    since_wake = ev.now_ms - wake_at;
    face_age   = ev.now_ms - last_face_at;
    res.status = psc_pkg::ST_FACE_IGNORED;
    case (ev.mode)
      psc_pkg::MODE_FACE: begin
        if (cfg_model.counter_enable && ev.face_seen) begin
          last_face_at = ev.now_ms;
          res.status = psc_pkg::ST_FACE_NOTED;
        end
      end
      psc_pkg::MODE_POLL: begin
        if (!cfg_model.counter_enable) begin
          res.status = psc_pkg::ST_DISABLED;
        end else if (ev.pipeline_busy) begin
          res.status = psc_pkg::ST_BUSY;
        end else if (cfg_model.sleep_override) begin
          res.status = psc_pkg::ST_OVERRIDE;
        end else if (!asleep_q) begin
          if (since_wake < cfg_model.wake_guard_ms) begin
            touch_prev = 1'b0;
            res.status = psc_pkg::ST_GRACE;
          end else if (face_age < cfg_model.presence_window_ms) begin
            res.status = psc_pkg::ST_PRESENT;
          end else if (face_age > cfg_model.sleep_timeout_ms) begin
            asleep_q = 1'b1;
            touch_prev = 1'b0;
            res.status = psc_pkg::ST_SLEPT;
          end else begin
            res.status = psc_pkg::ST_COUNTING;
          end
        end else if (ev.touch_valid && ev.touch_pressed && !touch_prev) begin
          asleep_q = 1'b0;
          touch_prev = 1'b1;
          last_face_at = ev.now_ms;
          wake_at = ev.now_ms;
          res.status = psc_pkg::ST_WOKEN;
        end else begin
          if (ev.touch_valid) touch_prev = ev.touch_pressed;
          res.status = psc_pkg::ST_ASLEEP;
        end
      end
      psc_pkg::MODE_RESTART: begin
        last_face_at = ev.now_ms;
        res.status = psc_pkg::ST_RESTARTED;
      end
      default: ;
    endcase
    res.asleep = asleep_q;
    return res;
  endfunction

  function automatic void flag_failure(string what);
    mismatch_count++;
    if (mismatch_count <= MaxReports) $display("%t: %s", $realtime, what);
  endfunction

  task automatic write_reg(logic [psc_pkg::CfgIdxW-1:0] idx,
                           logic [psc_pkg::CfgDataW-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    case (idx)
      psc_pkg::CFG_COUNTER_ENABLE: cfg_model.counter_enable = data[0];
      psc_pkg::CFG_SLEEP_OVERRIDE: cfg_model.sleep_override = data[0];
      psc_pkg::CFG_PRESENCE_WIN:   cfg_model.presence_window_ms = data;
      psc_pkg::CFG_SLEEP_TIMEOUT:  cfg_model.sleep_timeout_ms = data;
      psc_pkg::CFG_WAKE_GRACE:     cfg_model.wake_guard_ms = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic program_registers(logic enable, logic override,
                                   logic [psc_pkg::WinW-1:0] window,
                                   logic [psc_pkg::WinW-1:0] timeout,
                                   logic [psc_pkg::WinW-1:0] grace);
    write_reg(psc_pkg::CFG_COUNTER_ENABLE, {15'($urandom_range(0, 32767)), enable});
    write_reg(psc_pkg::CFG_SLEEP_OVERRIDE, {15'($urandom_range(0, 32767)), override});
    write_reg(psc_pkg::CFG_PRESENCE_WIN, window);
    write_reg(psc_pkg::CFG_SLEEP_TIMEOUT, timeout);
    write_reg(psc_pkg::CFG_WAKE_GRACE, grace);
  endtask

  task automatic queue_event(logic [psc_pkg::ModeW-1:0] mode, logic [psc_pkg::TimeW-1:0] now,
                             logic face, logic busy, logic tvalid, logic tpressed);
    pending_events.push_back('{mode, now, face, busy, tvalid, tpressed});
  endtask

  task automatic add_random_events(int unsigned count);
    sensor_event_t ev;
    int unsigned   span;
    int unsigned   pick;
    span = int'(cfg_model.sleep_timeout_ms) + int'(cfg_model.wake_guard_ms) + 2;
    for (int unsigned i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) clock_ms += $urandom_range(0, 200);
      else if (pick < 80) clock_ms += $urandom_range(0, span / 4);
      else if (pick < 97) clock_ms += $urandom_range(0, span);
      else clock_ms = $urandom;
      pick = $urandom_range(0, 99);
      if (pick < 55) ev.mode = psc_pkg::MODE_POLL;
      else if (pick < 82) ev.mode = psc_pkg::MODE_FACE;
      else if (pick < 97) ev.mode = psc_pkg::MODE_RESTART;
      else ev.mode = ModeUnused;
      if ($urandom_range(0, 9) < 3) touch_level = ~touch_level;
      ev.now_ms        = clock_ms;
      ev.face_seen     = $urandom_range(0, 9) < 7;
      ev.pipeline_busy = $urandom_range(0, 9) == 0;
      ev.touch_valid   = $urandom_range(0, 6) != 0;
      ev.touch_pressed = touch_level;
      pending_events.push_back(ev);
    end
  endtask

  task automatic wait_idle();
    while (pending_events.size() != 0 || in_ch.valid || awaited_results.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [psc_pkg::WinW-1:0] pick_span(int unsigned phase);
    if (phase == 2) return '0;
    if (phase == 4) return '1;
    case ($urandom_range(0, 4))
      0: return '0;
      1: return '1;
      default: return psc_pkg::WinW'($urandom_range(1, 4000));
    endcase
  endfunction

  always @(negedge clk) begin
    if (!in_ch.valid || in_fire) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_ch.valid <= 1'b0;
      end else if (pending_events.size() != 0) begin
        next_event = pending_events.pop_front();
        in_ch.valid         <= 1'b1;
        in_ch.mode          <= next_event.mode;
        in_ch.now_ms        <= next_event.now_ms;
        in_ch.face_seen     <= next_event.face_seen;
        in_ch.pipeline_busy <= next_event.pipeline_busy;
        in_ch.touch_valid   <= next_event.touch_valid;
        in_ch.touch_pressed <= next_event.touch_pressed;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 32);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else if (hold_requests != holds_served) begin
      holds_served <= holds_served + 1;
      hold_left <= HoldCycles;
      out_ch.ready <= 1'b0;
    end else begin
      if (run_left == 0) begin
        run_left <= $urandom_range(1, 40);
        stall_style <= stall_style_e'($urandom_range(0, 3));
      end else begin
        run_left <= run_left - 1;
      end
      case (stall_style)
        StallNone:  out_ch.ready <= 1'b1;
        StallHalf:  out_ch.ready <= 1'($urandom_range(0, 1));
        StallLight: out_ch.ready <= $urandom_range(0, 3) != 0;
        default:    out_ch.ready <= $urandom_range(0, 7) == 0;
      endcase
    end
  end

  always @(posedge clk) begin
    in_fire <= in_ch.valid && in_ch.ready;
    if (in_ch.valid && in_ch.ready) begin
      awaited_results.push_back(advance_sleep_model('{in_ch.mode, in_ch.now_ms,
          in_ch.face_seen, in_ch.pipeline_busy, in_ch.touch_valid, in_ch.touch_pressed}));
    end
    if (out_ch.valid && out_ch.ready) begin
      if (awaited_results.size() == 0) begin
        flag_failure($sformatf("unexpected result: asleep %0b status %0d",
                               out_ch.asleep, out_ch.status));
      end else begin
        seen_result = awaited_results.pop_front();
        if (out_ch.asleep !== seen_result.asleep || out_ch.status !== seen_result.status)
          flag_failure($sformatf("result mismatch: expected asleep %0b status %0d, got %0b %0d",
                                 seen_result.asleep, seen_result.status,
                                 out_ch.asleep, out_ch.status));
      end
    end
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_ni              = 1'b0;
    cfg_we              = 1'b0;
    cfg_idx             = '0;
    cfg_wdata           = '0;
    in_ch.valid         = 1'b0;
    in_ch.mode          = psc_pkg::MODE_FACE;
    in_ch.now_ms        = '0;
    in_ch.face_seen     = 1'b0;
    in_ch.pipeline_busy = 1'b0;
    in_ch.touch_valid   = 1'b0;
    in_ch.touch_pressed = 1'b0;
    out_ch.ready        = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_ni = 1'b1;

    // With reset values the counter is off, so reports and polls do nothing.
    queue_event(psc_pkg::MODE_FACE, 32'd10, 1'b1, 1'b0, 1'b0, 1'b0);
    queue_event(psc_pkg::MODE_POLL, 32'd20, 1'b0, 1'b0, 1'b1, 1'b1);
    queue_event(psc_pkg::MODE_RESTART, 32'd30, 1'b0, 1'b0, 1'b0, 1'b0);
    queue_event(ModeUnused, 32'd40, 1'b1, 1'b1, 1'b1, 1'b1);
    wait_idle();

    program_registers(1'b1, 1'b0, 16'd500, 16'd7000, 16'd1500);
    write_reg(CfgIdxSpare, 16'hFFFF);
    write_reg(CfgIdxTop, 16'h0000);
    queue_event(psc_pkg::MODE_FACE, 32'd100, 1'b0, 1'b0, 1'b0, 1'b0);
    queue_event(psc_pkg::MODE_FACE, 32'd100, 1'b1, 1'b0, 1'b0, 1'b0);
    queue_event(psc_pkg::MODE_POLL, 32'd200, 1'b0, 1'b1, 1'b0, 1'b0);
    queue_event(psc_pkg::MODE_POLL, 32'd300, 1'b0, 1'b0, 1'b0, 1'b0);
    queue_event(psc_pkg::MODE_POLL, 32'd1700, 1'b0, 1'b0, 1'b0, 1'b0);
    queue_event(psc_pkg::MODE_FACE, 32'd1700, 1'b1, 1'b0, 1'b0, 1'b0);
    queue_event(psc_pkg::MODE_POLL, 32'd1800, 1'b0, 1'b0, 1'b0, 1'b0);
    queue_event(psc_pkg::MODE_POLL, 32'd8700, 1'b0, 1'b0, 1'b0, 1'b0);
    queue_event(psc_pkg::MODE_POLL, 32'd8701, 1'b0, 1'b0, 1'b1, 1'b1);
    queue_event(psc_pkg::MODE_FACE, 32'd8800, 1'b1, 1'b0, 1'b0, 1'b0);
    queue_event(psc_pkg::MODE_POLL, 32'd8900, 1'b0, 1'b0, 1'b0, 1'b1);
    queue_event(psc_pkg::MODE_POLL, 32'd9000, 1'b0, 1'b0, 1'b1, 1'b0);
    queue_event(psc_pkg::MODE_POLL, 32'd9100, 1'b0, 1'b0, 1'b1, 1'b1);
    queue_event(psc_pkg::MODE_POLL, 32'd10599, 1'b0, 1'b0, 1'b1, 1'b1);
    queue_event(psc_pkg::MODE_POLL, 32'd10600, 1'b0, 1'b0, 1'b1, 1'b1);
    queue_event(psc_pkg::MODE_POLL, 32'd17601, 1'b0, 1'b1, 1'b1, 1'b1);
    queue_event(psc_pkg::MODE_POLL, 32'd17601, 1'b0, 1'b0, 1'b1, 1'b1);
    queue_event(psc_pkg::MODE_POLL, 32'd17700, 1'b0, 1'b0, 1'b1, 1'b1);
    // Timestamps wrap through zero between the restart and the next poll.
    queue_event(psc_pkg::MODE_RESTART, 32'hFFFF_FF00, 1'b0, 1'b0, 1'b0, 1'b0);
    queue_event(psc_pkg::MODE_POLL, 32'h0000_0010, 1'b0, 1'b0, 1'b0, 1'b0);
    queue_event(psc_pkg::MODE_POLL, 32'h0000_1C00, 1'b0, 1'b0, 1'b0, 1'b0);
    wait_idle();

    program_registers(1'b1, 1'b1, 16'd0, 16'd0, 16'd0);
    queue_event(psc_pkg::MODE_POLL, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b1, 1'b1);
    queue_event(psc_pkg::MODE_FACE, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 1'b1);
    wait_idle();

    clock_ms = 32'h0000_2000;
    for (int unsigned phase = 0; phase < PhaseCount; phase++) begin
      program_registers(phase != 1, phase == 3, pick_span(phase), pick_span(phase),
                        pick_span(phase));
      if (phase == 5) write_reg(CfgIdxSpare, psc_pkg::CfgDataW'($urandom));
      if ($urandom_range(0, 2) == 0) clock_ms = $urandom;
      add_random_events(PhaseEvents);
      if (phase == 2) hold_requests++;
      wait_idle();
    end

    repeat (8) @(posedge clk);
    mismatch_count += awaited_results.size();
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* filelist.f */
+incdir+design
design/psc_pkg.sv
design/psc_in_if.sv
design/psc_out_if.sv
design/psc_cfg_regs.sv
design/psc_engine.sv
design/presence_idle_sleep_controller_unit.sv
test/tb.sv
